// ----- hdl/msct_pkg.sv -----
// Package for the millidegree sine/cosine/tangent core.
// Holds the sine table, the angle constants and the reduction helpers.
// No dependencies.
`default_nettype none

package msct_pkg;

  localparam int unsigned MOD_STAGES = 5;
  localparam int unsigned MOD_STEPS  = 3;
  localparam int unsigned MOD_TOP    = 14;
  localparam int unsigned DIV_STAGES = 4;
  localparam int unsigned DIV_STEPS  = 5;
  localparam int unsigned NUM_W      = 20;
  localparam int unsigned REC_SHIFT  = 27;

  localparam logic signed [33:0] HALF_TURN_S    = 34'sd180000;
  localparam logic signed [33:0] QUARTER_TURN_S = 34'sd90000;
  localparam logic [32:0]        FULL_TURN_W    = 33'd360000;
  localparam logic [18:0]        HALF_TURN      = 19'd180000;
  localparam logic [18:0]        QUARTER_TURN   = 19'd90000;
  localparam logic [17:0]        RECIP_MILLI    = 18'd134218;
  localparam logic [16:0]        MILLI          = 17'd1000;
  localparam logic [9:0]         MILLI_10       = 10'd1000;
  localparam logic [6:0]         LAST_DEG       = 7'd90;
  localparam logic [31:0]        TAN_HUGE       = 32'h7FFF_FFFF;

  localparam logic [9:0] SIN_TAB [0:90] = '{
    10'd0,   10'd17,  10'd35,  10'd52,  10'd70,  10'd87,  10'd105, 10'd122,
    10'd139, 10'd156, 10'd174, 10'd191, 10'd208, 10'd225, 10'd242, 10'd259,
    10'd276, 10'd292, 10'd309, 10'd326, 10'd342, 10'd358, 10'd375, 10'd391,
    10'd407, 10'd423, 10'd438, 10'd454, 10'd469, 10'd485, 10'd500, 10'd515,
    10'd530, 10'd545, 10'd559, 10'd574, 10'd588, 10'd602, 10'd616, 10'd629,
    10'd643, 10'd656, 10'd669, 10'd682, 10'd695, 10'd707, 10'd719, 10'd731,
    10'd743, 10'd755, 10'd766, 10'd777, 10'd788, 10'd799, 10'd809, 10'd819,
    10'd829, 10'd839, 10'd848, 10'd857, 10'd866, 10'd875, 10'd883, 10'd891,
    10'd899, 10'd906, 10'd914, 10'd921, 10'd927, 10'd934, 10'd940, 10'd946,
    10'd951, 10'd956, 10'd961, 10'd966, 10'd970, 10'd974, 10'd978, 10'd982,
    10'd985, 10'd988, 10'd990, 10'd993, 10'd995, 10'd996, 10'd998, 10'd999,
    10'd999, 10'd1000, 10'd1000
  };

  function automatic logic [9:0] sin_lookup(input logic [6:0] idx);
    logic [9:0] val;
    val = '0;
    if (idx <= LAST_DEG) begin
      val = SIN_TAB[idx];
    end
    return val;
  endfunction

  // negative angle a becomes 180000 - a
  function automatic logic [32:0] fold_neg(input logic signed [33:0] x);
    logic signed [33:0] y;
    y = (x < 0) ? (HALF_TURN_S - x) : x;
    return y[32:0];
  endfunction

  // conditional subtracts of 360000 * 2^k, k from top downward
  function automatic logic [32:0] mod_steps(input logic [32:0] x, input int unsigned top);
    logic [32:0] y;
    logic [32:0] m;
    y = x;
    m = '0;
    for (int unsigned t = 0; t < MOD_STEPS; t++) begin
      m = FULL_TURN_W << (top - t);
      if (y >= m) begin
        y = y - m;
      end
    end
    return y;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/millidegree_sine_cosine_tangent_core.sv -----
// Sine, cosine and tangent of an angle in millidegrees, scaled by 1000.
// Uses msct_pkg (table, constants, reduction helpers).
//
// Input channel: angle_mdeg with angle_valid / angle_stall.
// Output channel: sine_milli, cosine_milli, tangent_milli with
// result_valid / result_stall. A beat moves when valid is high and
// stall is low.
// Throughput: one beat per cycle when the output is not stalled.
// The pipeline is 18 register stages: sign fold, five stages of modulo
// 360000 by conditional subtraction, quadrant fold, reciprocal multiply,
// table lookup, interpolation multiply, reciprocal multiply, sign,
// divider setup, four stages of restoring division (five quotient bits
// each) and the output register.
// Each stage holds its own valid bit; a stage loads whenever it is empty
// or the stage after it moves, so bubbles close up under stall.
// When result_stall is held, the pipeline fills and then angle_stall
// rises; nothing is dropped or repeated.
// Reset (rst, synchronous) clears all valid bits.
`default_nettype none

module millidegree_sine_cosine_tangent_core
  import msct_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               angle_valid,
  output logic                    angle_stall,
  input  wire logic signed [31:0] angle_mdeg,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output logic signed [10:0]      sine_milli,
  output logic signed [10:0]      cosine_milli,
  output logic signed [31:0]      tangent_milli
);

  localparam int unsigned NST = 18;
  localparam int unsigned S_QUAD = 6;
  localparam int unsigned S_MUL = 7;
  localparam int unsigned S_TAB = 8;
  localparam int unsigned S_PRD = 9;
  localparam int unsigned S_REC = 10;
  localparam int unsigned S_SGN = 11;
  localparam int unsigned S_DSU = 12;
  localparam int unsigned S_DIV = 13;
  localparam int unsigned S_OUT = 17;

  logic [NST-1:0] vld;
  logic [NST-1:0] rdy;

  always_comb begin
    rdy[NST-1] = !vld[NST-1] || !result_stall;
    for (int i = NST - 2; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign angle_stall  = !rdy[0];
  assign result_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= angle_valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // lane 0 is sine, lane 1 is cosine
  logic signed [33:0] ang_ext;
  logic signed [33:0] ang_cos;
  assign ang_ext = 34'(angle_mdeg);
  assign ang_cos = ang_ext + QUARTER_TURN_S;

  logic [32:0] mod_x [0:MOD_STAGES][2];

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      mod_x[0][0] <= fold_neg(ang_ext);
      mod_x[0][1] <= fold_neg(ang_cos);
    end
  end

  for (genvar j = 1; j <= MOD_STAGES; j++) begin : g_mod
    always_ff @(posedge clk) begin
      if (rdy[j]) begin
        for (int l = 0; l < 2; l++) begin
          mod_x[j][l] <= mod_steps(mod_x[j-1][l], MOD_TOP - MOD_STEPS * (j - 1));
        end
      end
    end
  end

  logic [16:0] quad_r   [2];
  logic        quad_neg [2];
  logic [6:0]  mul_d    [2];
  logic [16:0] mul_r    [2];
  logic        mul_neg  [2];
  logic [9:0]  tab_frac [2];
  logic [9:0]  tab_y1   [2];
  logic [4:0]  tab_diff [2];
  logic        tab_neg  [2];
  logic [14:0] prd_p    [2];
  logic [9:0]  prd_y1   [2];
  logic        prd_neg  [2];
  logic [4:0]  rec_q    [2];
  logic [9:0]  rec_y1   [2];
  logic        rec_neg  [2];
  logic signed [10:0] sgn_val [2];

  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      logic [18:0] r;
      logic [18:0] r1;
      logic [34:0] prod;
      logic [6:0]  dn;
      logic [9:0]  y2;
      logic [32:0] qp;
      logic [10:0] mag;
      r    = mod_x[MOD_STAGES][l][18:0];
      r1   = (r >= HALF_TURN) ? (r - HALF_TURN) : r;
      prod = 35'(quad_r[l]) * 35'(RECIP_MILLI);
      dn   = (mul_d[l] == LAST_DEG) ? LAST_DEG : (mul_d[l] + 7'd1);
      y2   = sin_lookup(dn);
      qp   = 33'(prd_p[l]) * 33'(RECIP_MILLI);
      mag  = 11'(rec_y1[l]) + 11'(rec_q[l]);
      if (rdy[S_QUAD]) begin
        quad_neg[l] <= (r >= HALF_TURN);
        quad_r[l]   <= (r1 >= QUARTER_TURN) ? 17'(HALF_TURN - r1) : r1[16:0];
      end
      if (rdy[S_MUL]) begin
        mul_d[l]   <= prod[REC_SHIFT +: 7];
        mul_r[l]   <= quad_r[l];
        mul_neg[l] <= quad_neg[l];
      end
      if (rdy[S_TAB]) begin
        tab_frac[l] <= 10'(mul_r[l] - 17'(mul_d[l]) * MILLI);
        tab_y1[l]   <= sin_lookup(mul_d[l]);
        tab_diff[l] <= 5'(y2 - sin_lookup(mul_d[l]));
        tab_neg[l]  <= mul_neg[l];
      end
      if (rdy[S_PRD]) begin
        prd_p[l]   <= 15'(tab_diff[l]) * 15'(tab_frac[l]);
        prd_y1[l]  <= tab_y1[l];
        prd_neg[l] <= tab_neg[l];
      end
      if (rdy[S_REC]) begin
        rec_q[l]   <= qp[REC_SHIFT +: 5];
        rec_y1[l]  <= prd_y1[l];
        rec_neg[l] <= prd_neg[l];
      end
      if (rdy[S_SGN]) begin
        sgn_val[l] <= rec_neg[l] ? -$signed(mag) : $signed(mag);
      end
    end
  end

  logic [NUM_W-1:0]   dv_num  [0:DIV_STAGES];
  logic [10:0]        dv_rem  [0:DIV_STAGES];
  logic [9:0]         dv_den  [0:DIV_STAGES];
  logic               dv_neg  [0:DIV_STAGES];
  logic               dv_zero [0:DIV_STAGES];
  logic signed [10:0] dv_sin  [0:DIV_STAGES];
  logic signed [10:0] dv_cos  [0:DIV_STAGES];

  always_ff @(posedge clk) begin
    logic [9:0] smag;
    logic [9:0] cmag;
    smag = sgn_val[0][10] ? 10'(-sgn_val[0]) : sgn_val[0][9:0];
    cmag = sgn_val[1][10] ? 10'(-sgn_val[1]) : sgn_val[1][9:0];
    if (rdy[S_DSU]) begin
      dv_num[0]  <= NUM_W'(smag) * NUM_W'(MILLI_10);
      dv_rem[0]  <= '0;
      dv_den[0]  <= cmag;
      dv_neg[0]  <= sgn_val[0][10] ^ sgn_val[1][10];
      dv_zero[0] <= (sgn_val[1] == 11'sd0);
      dv_sin[0]  <= sgn_val[0];
      dv_cos[0]  <= sgn_val[1];
    end
  end

  // quotient bits shift into the low end of dv_num
  for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_div
    always_ff @(posedge clk) begin
      logic [NUM_W-1:0] n;
      logic [10:0]      rm;
      logic [11:0]      r2;
      n  = dv_num[j-1];
      rm = dv_rem[j-1];
      r2 = '0;
      for (int unsigned t = 0; t < DIV_STEPS; t++) begin
        r2 = {rm, n[NUM_W-1]};
        n  = {n[NUM_W-2:0], 1'b0};
        if (r2 >= 12'(dv_den[j-1])) begin
          r2   = r2 - 12'(dv_den[j-1]);
          n[0] = 1'b1;
        end
        rm = r2[10:0];
      end
      if (rdy[S_DIV + j - 1]) begin
        dv_num[j]  <= n;
        dv_rem[j]  <= rm;
        dv_den[j]  <= dv_den[j-1];
        dv_neg[j]  <= dv_neg[j-1];
        dv_zero[j] <= dv_zero[j-1];
        dv_sin[j]  <= dv_sin[j-1];
        dv_cos[j]  <= dv_cos[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[S_OUT]) begin
      sine_milli   <= dv_sin[DIV_STAGES];
      cosine_milli <= dv_cos[DIV_STAGES];
      if (dv_zero[DIV_STAGES]) begin
        tangent_milli <= $signed(TAN_HUGE);
      end else if (dv_neg[DIV_STAGES]) begin
        tangent_milli <= -$signed(32'(dv_num[DIV_STAGES]));
      end else begin
        tangent_milli <= $signed(32'(dv_num[DIV_STAGES]));
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/msct_checker.sv -----
// Port-level checker for the millidegree sine/cosine/tangent core.
// Uses msct_pkg; bound to millidegree_sine_cosine_tangent_core below.
`default_nettype none

module msct_checker
  import msct_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               result_valid,
  input wire logic               result_stall,
  input wire logic signed [10:0] sine_milli,
  input wire logic signed [10:0] cosine_milli,
  input wire logic signed [31:0] tangent_milli
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(tangent_milli))
    else $error("stalled result beat changed");

  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result beat right after reset");

  a_tan_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && cosine_milli == 11'sd0 |-> tangent_milli == $signed(TAN_HUGE))
    else $error("zero cosine without saturated tangent");

  a_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> sine_milli <= 11'sd1000 && sine_milli >= -11'sd1000
      && cosine_milli <= 11'sd1000 && cosine_milli >= -11'sd1000)
    else $error("sine or cosine out of range");

endmodule

bind millidegree_sine_cosine_tangent_core msct_checker u_msct_checker (
  .clk(clk),
  .rst(rst),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .sine_milli(sine_milli),
  .cosine_milli(cosine_milli),
  .tangent_milli(tangent_milli)
);

`default_nettype wire
